### hw/rtl/mvt_pkg.sv
// Shared types, constants and helpers for the 4x4 matrix by vector transform.
package mvt_pkg;

   localparam int FP_W      = 32;
   localparam int VEC_N     = 4;
   localparam int VEC_W     = FP_W * VEC_N;
   localparam int NUM_PAIRS = 8;
   localparam int PAIR_W    = 2 * FP_W;
   localparam int CSR_IDX_W = 8;
   localparam int PROD_W    = 48;
   localparam int EXP_W     = 11;
   localparam int LZ_W      = 6;
   localparam int EF_W      = 10;
   localparam int STAGES    = 12;
   localparam int OP_STAGES = 3;

   localparam logic [FP_W-1:0] QNAN = 32'h7FC0_0000;

   localparam logic [PAIR_W-1:0] MAT_RESET [NUM_PAIRS] = '{
      64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
   };

   // unrounded result: value = m * 2^(e0 - 127 - 47) when not special
   typedef struct packed {
      logic                    nan;
      logic                    inf;
      logic                    zero;
      logic                    sign;
      logic signed [EXP_W-1:0] e0;
      logic [PROD_W-1:0]       m;
   } unr_type;

   typedef struct packed {
      logic              nan;
      logic              inf;
      logic              zero;
      logic              sign;
      logic [EF_W-1:0]   ef;
      logic [PROD_W-1:0] n;
   } nrm_type;

   function automatic logic [LZ_W-1:0] lzc48(input logic [PROD_W-1:0] m);
      logic [LZ_W-1:0] lz;
      lz = LZ_W'(PROD_W);
      for (int i = 0; i < PROD_W; i++) begin
         if (m[i]) lz = LZ_W'(PROD_W - 1 - i);
      end
      return lz;
   endfunction

endpackage

### hw/rtl/mvt_fmul_front.sv
// Single-precision multiply, first stage: unpack, specials and mantissa product.
module mvt_fmul_front (
   input  logic                     clock,
   input  logic                     en,
   input  logic [mvt_pkg::FP_W-1:0] a,
   input  logic [mvt_pkg::FP_W-1:0] b,
   output mvt_pkg::unr_type         q
);
   import mvt_pkg::*;

   logic [7:0]  ea, eb, ea_eff, eb_eff;
   logic [23:0] ma, mb;
   logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
   unr_type     q_in, q_ff;

   always_comb begin
      ea     = a[30:23];
      eb     = b[30:23];
      ea_eff = (ea == 8'd0) ? 8'd1 : ea;
      eb_eff = (eb == 8'd0) ? 8'd1 : eb;
      ma     = {ea != 8'd0, a[22:0]};
      mb     = {eb != 8'd0, b[22:0]};
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
      a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
      q_in.nan  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
      q_in.inf  = a_inf || b_inf;
      q_in.zero = a_zero || b_zero;
      q_in.sign = a[31] ^ b[31];
      // product MSB at bit 47 carries biased exponent ea + eb - 126
      q_in.e0   = EXP_W'(ea_eff) + EXP_W'(eb_eff) - EXP_W'(126);
      q_in.m    = PROD_W'(ma) * PROD_W'(mb);
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

### hw/rtl/mvt_fadd_front.sv
// Single-precision add, first stage: specials, swap, align and mantissa add.
module mvt_fadd_front (
   input  logic                     clock,
   input  logic                     en,
   input  logic [mvt_pkg::FP_W-1:0] a,
   input  logic [mvt_pkg::FP_W-1:0] b,
   output mvt_pkg::unr_type         q
);
   import mvt_pkg::*;

   logic [31:0] big, sml;
   logic [7:0]  eb, es, eb_eff, es_eff, d;
   logic [26:0] mb_ext, ms_ext, shd, al;
   logic [27:0] sum;
   logic        lost, sub;
   logic        a_inf, b_inf, a_nan, b_nan;
   unr_type     q_in, q_ff;

   always_comb begin
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb     = big[30:23];
      es     = sml[30:23];
      eb_eff = (eb == 8'd0) ? 8'd1 : eb;
      es_eff = (es == 8'd0) ? 8'd1 : es;
      d      = eb_eff - es_eff;
      mb_ext = {eb != 8'd0, big[22:0], 3'b000};
      ms_ext = {es != 8'd0, sml[22:0], 3'b000};
      shd    = ms_ext >> d;
      lost   = ((shd << d) != ms_ext);
      al     = {shd[26:1], shd[0] | lost};
      sub    = big[31] ^ sml[31];
      sum    = sub ? ({1'b0, mb_ext} - {1'b0, al}) : ({1'b0, mb_ext} + {1'b0, al});

      q_in.nan  = a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
      q_in.inf  = a_inf || b_inf;
      q_in.zero = (sum == 28'd0);
      // exact zero is +0 unless both operands are negative
      q_in.sign = q_in.zero ? (a[31] & b[31]) : big[31];
      q_in.e0   = EXP_W'(eb_eff) + EXP_W'(1);
      q_in.m    = {sum, 20'd0};
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

### hw/rtl/mvt_round.sv
// Normalise (one stage) and round-to-nearest-even pack (one stage).
module mvt_round (
   input  logic                     clock,
   input  logic                     en,
   input  mvt_pkg::unr_type         d,
   output logic [mvt_pkg::FP_W-1:0] q
);
   import mvt_pkg::*;

   logic [LZ_W-1:0]  lz;
   logic signed [11:0] e0m1;
   logic [6:0]       rsh;
   logic [PROD_W-1:0] shd;
   logic             lost;
   nrm_type          nrm_in, nrm_ff;

   logic [23:0]      mant;
   logic             inc;
   logic [30:0]      mag;
   logic [FP_W-1:0]  q_in, q_ff;

   always_comb begin
      lz   = lzc48(d.m);
      e0m1 = {d.e0[EXP_W-1], d.e0} - 12'sd1;
      rsh  = 7'(-e0m1);
      shd  = d.m >> rsh;
      lost = ((shd << rsh) != d.m);
      nrm_in.nan  = d.nan;
      nrm_in.inf  = d.inf;
      nrm_in.zero = d.zero;
      nrm_in.sign = d.sign;
      if (e0m1 < 12'sd0) begin
         // below the normal range: denormalise with sticky
         nrm_in.n  = {shd[PROD_W-1:1], shd[0] | lost};
         nrm_in.ef = '0;
      end else if ($signed({6'd0, lz}) <= e0m1) begin
         nrm_in.n  = d.m << lz;
         nrm_in.ef = EF_W'(d.e0 - EXP_W'(lz));
      end else begin
         nrm_in.n  = d.m << e0m1[LZ_W-1:0];
         nrm_in.ef = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) nrm_ff <= nrm_in;
   end

   always_comb begin
      mant = nrm_ff.n[47:24];
      inc  = nrm_ff.n[23] & ((|nrm_ff.n[22:0]) | mant[0]);
      // carry out of the fraction walks into the exponent, to inf if need be
      mag  = {nrm_ff.ef[7:0], mant[22:0]} + 31'(inc);
      if (nrm_ff.nan)
         q_in = QNAN;
      else if (nrm_ff.inf || (nrm_ff.ef >= EF_W'(255)))
         q_in = {nrm_ff.sign, 8'hFF, 23'd0};
      else if (nrm_ff.zero)
         q_in = {nrm_ff.sign, 31'd0};
      else
         q_in = {nrm_ff.sign, mag};
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

### hw/rtl/mat4_vec4_transform_core.sv
// Top level: 4x4 single-precision matrix times 4-vector, fully pipelined.
// One vector is taken per cycle; each multiply and each of the three chained
// adds is a 3-stage unit (operate, normalise, round), and a vector passes the
// products first and then the three chained adds, in that order.
// The whole pipe advances together; it halts only while a result
// sits in the output stage unread, so req_tready follows rsp_tready then.
// Results are rounded to nearest-even after each product and each sum, in
// the order ((p0 + p1) + p2) + p3, subnormals kept; any NaN result reads as
// 0x7FC00000. The matrix lives in eight 64-bit registers, column-major, two
// elements each (even element in the low word), reset to identity; writes
// to an index above seven are dropped. The configuration port is always
// ready and must only be written while no item is in flight.
module mat4_vec4_transform_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [mvt_pkg::VEC_W-1:0]   req_tdata,   // vec_x, vec_y, vec_z, vec_w
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mvt_pkg::VEC_W-1:0]   rsp_tdata,   // out_x, out_y, out_z, out_w
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mvt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mvt_pkg::PAIR_W-1:0]  csr_data
);
   import mvt_pkg::*;

   logic [PAIR_W-1:0] mat_ff [NUM_PAIRS];
   logic [STAGES-1:0] vld_ff, vld_in;
   logic              adv;

   logic [FP_W-1:0]   vec  [VEC_N];
   logic [FP_W-1:0]   elem [16];
   logic [FP_W-1:0]   prod [VEC_N][VEC_N];   // [row][term]
   logic [FP_W-1:0]   s1   [VEC_N];
   logic [FP_W-1:0]   s2   [VEC_N];
   logic [FP_W-1:0]   s3   [VEC_N];

   // matrix registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAIRS; i++) mat_ff[i] <= MAT_RESET[i];
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_PAIRS)) begin
         mat_ff[csr_index[2:0]] <= csr_data;
      end
   end

   always_comb begin
      for (int j = 0; j < 16; j++) elem[j] = mat_ff[j/2][(j%2)*FP_W +: FP_W];
      for (int k = 0; k < VEC_N; k++) vec[k] = req_tdata[k*FP_W +: FP_W];
   end

   // pipe control: everything moves unless the output stage is held
   assign adv        = !vld_ff[STAGES-1] || rsp_tready;
   assign req_tready = adv;
   assign vld_in     = {vld_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // per row: four products, then a chain of three adds
   for (genvar r = 0; r < VEC_N; r++) begin : g_row
      unr_type         a1_u, a2_u, a3_u;
      logic [FP_W-1:0] p2_dly_ff [OP_STAGES];
      logic [FP_W-1:0] p3_dly_ff [2*OP_STAGES];

      for (genvar k = 0; k < VEC_N; k++) begin : g_term
         unr_type mu;
         mvt_fmul_front u_mul (
            .clock(clock), .en(adv), .a(vec[k]), .b(elem[r + 4*k]), .q(mu)
         );
         mvt_round u_mrnd (.clock(clock), .en(adv), .d(mu), .q(prod[r][k]));
      end

      // line p2 and p3 up with the partial sums
      always_ff @(posedge clock) begin
         if (adv) begin
            p2_dly_ff[0] <= prod[r][2];
            for (int i = 1; i < OP_STAGES; i++) p2_dly_ff[i] <= p2_dly_ff[i-1];
            p3_dly_ff[0] <= prod[r][3];
            for (int i = 1; i < 2*OP_STAGES; i++) p3_dly_ff[i] <= p3_dly_ff[i-1];
         end
      end

      mvt_fadd_front u_add1 (
         .clock(clock), .en(adv), .a(prod[r][0]), .b(prod[r][1]), .q(a1_u)
      );
      mvt_round u_arnd1 (.clock(clock), .en(adv), .d(a1_u), .q(s1[r]));

      mvt_fadd_front u_add2 (
         .clock(clock), .en(adv), .a(s1[r]), .b(p2_dly_ff[OP_STAGES-1]), .q(a2_u)
      );
      mvt_round u_arnd2 (.clock(clock), .en(adv), .d(a2_u), .q(s2[r]));

      mvt_fadd_front u_add3 (
         .clock(clock), .en(adv), .a(s2[r]), .b(p3_dly_ff[2*OP_STAGES-1]), .q(a3_u)
      );
      mvt_round u_arnd3 (.clock(clock), .en(adv), .d(a3_u), .q(s3[r]));

      assign rsp_tdata[r*FP_W +: FP_W] = s3[r];
   end

   assign rsp_tvalid = vld_ff[STAGES-1];

   // NaN results on out_x only ever leave in canonical form
   a_qnan: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[30:23] == 8'hFF && rsp_tdata[22:0] != 23'd0)
      |-> rsp_tdata[31:0] == QNAN)
      else $error("non-canonical NaN on out_x");

   // a held output stage freezes the first stage as well
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !adv) |=> vld_ff[0])
      else $error("item lost in first stage during stall");

   // an in-range register write lands
   a_csr: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index < CSR_IDX_W'(NUM_PAIRS))
      |=> mat_ff[$past(csr_index[2:0])] == $past(csr_data))
      else $error("matrix register write lost");

endmodule
